// ----- hdl/assert_macros.svh -----
// assertion helpers shared by the checker
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// consequent checked in the same cycle as the trigger
`define ASSERT_SAME(label, trig, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cons)) \
        else $error("assertion failed");

// consequent checked in the cycle after the trigger
`define ASSERT_NEXT(label, trig, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- hdl/jtok_pkg.sv -----
// ---------------------------------------------------------------------------
// jtok_pkg
// token kinds, result group type and character helpers for the json tokenizer
// ---------------------------------------------------------------------------
package jtok_pkg;

    localparam logic [3:0] KIND_LBRACE = 4'd0;
    localparam logic [3:0] KIND_RBRACE = 4'd1;
    localparam logic [3:0] KIND_LBRACK = 4'd2;
    localparam logic [3:0] KIND_RBRACK = 4'd3;
    localparam logic [3:0] KIND_COLON  = 4'd4;
    localparam logic [3:0] KIND_COMMA  = 4'd5;
    localparam logic [3:0] KIND_NUMBER = 4'd6;
    localparam logic [3:0] KIND_STRING = 4'd7;
    localparam logic [3:0] KIND_TRUE   = 4'd8;
    localparam logic [3:0] KIND_ERROR  = 4'd11;
    localparam logic [3:0] KIND_END    = 4'd12;

    localparam int GROUP_SLOTS = 3;

    typedef struct packed {
        logic [3:0]  kind;
        logic [15:0] start;
        logic [15:0] length;
    } token_t;

    typedef struct packed {
        token_t [GROUP_SLOTS-1:0] tok;
        logic [1:0]               cnt;
    } grp_t;

    // letters of true, false and null; unused tail positions hold zero
    function automatic logic [7:0] word_char(input logic [1:0] sel, input logic [2:0] idx);
        logic [7:0] c;
        c = 8'h00;
        unique case (sel)
            2'd0:
            begin
                unique case (idx)
                    3'd0: c = "t";
                    3'd1: c = "r";
                    3'd2: c = "u";
                    3'd3: c = "e";
                    default: c = 8'h00;
                endcase
            end
            2'd1:
            begin
                unique case (idx)
                    3'd0: c = "f";
                    3'd1: c = "a";
                    3'd2: c = "l";
                    3'd3: c = "s";
                    3'd4: c = "e";
                    default: c = 8'h00;
                endcase
            end
            default:
            begin
                unique case (idx)
                    3'd0: c = "n";
                    3'd1: c = "u";
                    3'd2: c = "l";
                    3'd3: c = "l";
                    default: c = 8'h00;
                endcase
            end
        endcase
        return c;
    endfunction

    function automatic logic [2:0] word_len(input logic [1:0] sel);
        return (sel == 2'd1) ? 3'd5 : 3'd4;
    endfunction

endpackage

// ----- hdl/jtok_lexer.sv -----
// ---------------------------------------------------------------------------
// jtok_lexer
// scanner state and the per-byte token decision; gives a group of up to
// three tokens for each stepped byte
// ---------------------------------------------------------------------------
module jtok_lexer #(
    parameter int unsigned MAX_DOCUMENT_BYTES = 65536,
    parameter int unsigned NUMBER_LIMIT       = 128
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            step,
    input  logic [7:0]      data_byte,
    input  logic            end_of_input,
    output jtok_pkg::grp_t  grp
);
    import jtok_pkg::*;

    localparam logic [2:0] MODE_IDLE    = 3'd0;
    localparam logic [2:0] MODE_NUMBER  = 3'd1;
    localparam logic [2:0] MODE_STRING  = 3'd2;
    localparam logic [2:0] MODE_LITERAL = 3'd3;
    localparam logic [2:0] MODE_ERROR   = 3'd4;

    localparam int unsigned CAP_INT =
        (MAX_DOCUMENT_BYTES - 1 > 65535) ? 65535 : MAX_DOCUMENT_BYTES - 1;
    localparam logic [15:0] POS_CAP = CAP_INT[15:0];
    localparam logic [15:0] NUM_LIM = NUMBER_LIMIT[15:0];

    logic [2:0]  mode_reg, mode_next;
    logic [1:0]  phase_reg, phase_next;
    logic [1:0]  lsel_reg, lsel_next;
    logic [2:0]  lidx_reg, lidx_next;
    logic        pbs_reg, pbs_next;
    logic [15:0] pos_reg, pos_next;
    logic [15:0] start_reg, start_next;
    logic [15:0] run_reg, run_next;

    // candidate tokens in emission order: scan, fresh byte, end close, end marker
    token_t      cand [4];
    logic [3:0]  cand_en;

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    always_comb
    begin
        logic        fresh;
        logic        bad;
        logic        is_digit;
        logic        is_sign;
        logic        is_space;
        logic [1:0]  sel;
        logic [2:0]  idx;
        logic [1:0]  n;

        mode_next  = mode_reg;
        phase_next = phase_reg;
        lsel_next  = lsel_reg;
        lidx_next  = lidx_reg;
        pbs_next   = pbs_reg;
        start_next = start_reg;
        run_next   = run_reg;
        pos_next   = pos_reg;
        fresh      = 1'b0;
        bad        = 1'b0;
        cand_en    = 4'b0000;
        for (int i = 0; i < 4; i++)
        begin
            cand[i] = '{kind: KIND_ERROR, start: start_reg, length: run_reg};
        end

        is_digit = (data_byte >= "0") && (data_byte <= "9");
        is_sign  = (data_byte == "+") || (data_byte == "-");
        is_space = (data_byte == " ") || (data_byte == 8'h09) ||
                   (data_byte == 8'h0A) || (data_byte == 8'h0D);
        sel = (lsel_reg == 2'd3) ? 2'd2 : lsel_reg;
        idx = (lidx_reg > 3'd4) ? 3'd4 : lidx_reg;

        unique case (mode_reg)
            MODE_NUMBER:
            begin
                if (is_digit || is_sign || data_byte == ".")
                begin
                    if (run_reg >= NUM_LIM || is_sign)
                        bad = 1'b1;
                    else if (is_digit)
                        phase_next = (phase_reg >= 2'd2) ? 2'd3 : 2'd1;
                    else if (phase_reg <= 2'd1)
                        phase_next = (phase_reg == 2'd0) ? 2'd2 : 2'd3;
                    else
                        bad = 1'b1;
                    run_next = sat_inc(run_reg);
                    if (bad)
                    begin
                        cand_en[0] = 1'b1;
                        cand[0]    = '{kind: KIND_ERROR, start: start_reg, length: run_next};
                        mode_next  = MODE_ERROR;
                    end
                end
                else
                begin
                    cand_en[0] = 1'b1;
                    if (phase_reg[0])
                    begin
                        cand[0]   = '{kind: KIND_NUMBER, start: start_reg, length: run_reg};
                        mode_next = MODE_IDLE;
                        fresh     = 1'b1;
                    end
                    else
                    begin
                        mode_next = MODE_ERROR;
                    end
                end
            end
            MODE_STRING:
            begin
                run_next = sat_inc(run_reg);
                if (data_byte == "\"" && !pbs_reg)
                begin
                    cand_en[0] = 1'b1;
                    cand[0]    = '{kind: KIND_STRING, start: start_reg, length: run_next};
                    mode_next  = MODE_IDLE;
                end
                pbs_next = (data_byte == "\\");
            end
            MODE_LITERAL:
            begin
                if (data_byte == word_char(sel, idx))
                begin
                    run_next  = sat_inc(run_reg);
                    lidx_next = idx + 3'd1;
                    if (lidx_next >= word_len(sel))
                    begin
                        cand_en[0] = 1'b1;
                        cand[0]    = '{kind: KIND_TRUE + {2'b00, sel}, start: start_reg,
                                       length: run_next};
                        mode_next  = MODE_IDLE;
                    end
                end
                else
                begin
                    cand_en[0] = 1'b1;
                    cand[0]    = '{kind: KIND_ERROR, start: start_reg,
                                   length: sat_inc(run_reg)};
                    mode_next  = MODE_ERROR;
                end
            end
            MODE_IDLE:
            begin
                fresh = 1'b1;
            end
            default:
            begin
                mode_next = MODE_ERROR;
            end
        endcase

        // byte seen between tokens
        if (fresh && !is_space)
        begin
            cand[1] = '{kind: KIND_ERROR, start: pos_reg, length: 16'd1};
            priority if (data_byte == "{")
            begin
                cand_en[1] = 1'b1;
                cand[1].kind = KIND_LBRACE;
            end
            else if (data_byte == "}")
            begin
                cand_en[1] = 1'b1;
                cand[1].kind = KIND_RBRACE;
            end
            else if (data_byte == "[")
            begin
                cand_en[1] = 1'b1;
                cand[1].kind = KIND_LBRACK;
            end
            else if (data_byte == "]")
            begin
                cand_en[1] = 1'b1;
                cand[1].kind = KIND_RBRACK;
            end
            else if (data_byte == ":")
            begin
                cand_en[1] = 1'b1;
                cand[1].kind = KIND_COLON;
            end
            else if (data_byte == ",")
            begin
                cand_en[1] = 1'b1;
                cand[1].kind = KIND_COMMA;
            end
            else if (is_digit || is_sign)
            begin
                mode_next  = MODE_NUMBER;
                start_next = pos_reg;
                run_next   = 16'd1;
                phase_next = is_digit ? 2'd1 : 2'd0;
            end
            else if (data_byte == "\"")
            begin
                mode_next  = MODE_STRING;
                start_next = pos_reg;
                run_next   = 16'd1;
                pbs_next   = 1'b0;
            end
            else if (data_byte == "t" || data_byte == "f" || data_byte == "n")
            begin
                mode_next  = MODE_LITERAL;
                start_next = pos_reg;
                run_next   = 16'd1;
                lsel_next  = (data_byte == "t") ? 2'd0 : (data_byte == "f") ? 2'd1 : 2'd2;
                lidx_next  = 3'd1;
            end
            else
            begin
                cand_en[1] = 1'b1;
                mode_next  = MODE_ERROR;
            end
        end

        if (pos_reg < POS_CAP)
            pos_next = pos_reg + 16'd1;

        if (end_of_input)
        begin
            cand[2] = '{kind: KIND_ERROR, start: start_next, length: run_next};
            if (mode_next == MODE_NUMBER)
            begin
                cand_en[2] = 1'b1;
                if (phase_next[0])
                    cand[2].kind = KIND_NUMBER;
            end
            else if (mode_next == MODE_STRING)
            begin
                cand_en[2] = 1'b1;
            end
            else if (mode_next == MODE_LITERAL)
            begin
                cand_en[2]   = 1'b1;
                cand[2].kind = KIND_TRUE + {2'b00, (lsel_next == 2'd3) ? 2'd2 : lsel_next};
            end
            cand_en[3] = 1'b1;
            cand[3]    = '{kind: KIND_END, start: pos_next, length: 16'd0};
            // next document starts from a clean state
            mode_next  = MODE_IDLE;
            phase_next = 2'd0;
            lsel_next  = 2'd0;
            lidx_next  = 3'd0;
            pbs_next   = 1'b0;
            pos_next   = 16'd0;
            start_next = 16'd0;
            run_next   = 16'd0;
        end

        // pack enabled candidates in order, dropping any beyond three
        grp.tok = '0;
        n = 2'd0;
        for (int i = 0; i < 4; i++)
        begin
            if (cand_en[i] && n != 2'd3)
            begin
                grp.tok[n] = cand[i];
                n = n + 2'd1;
            end
        end
        grp.cnt = n;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            phase_reg <= 2'd0;
            lsel_reg  <= 2'd0;
            lidx_reg  <= 3'd0;
            pbs_reg   <= 1'b0;
            pos_reg   <= 16'd0;
            start_reg <= 16'd0;
            run_reg   <= 16'd0;
        end
        else if (step)
        begin
            mode_reg  <= mode_next;
            phase_reg <= phase_next;
            lsel_reg  <= lsel_next;
            lidx_reg  <= lidx_next;
            pbs_reg   <= pbs_next;
            pos_reg   <= pos_next;
            start_reg <= start_next;
            run_reg   <= run_next;
        end
    end

endmodule

// ----- hdl/jtok_serializer.sv -----
// ---------------------------------------------------------------------------
// jtok_serializer
// result register holding one byte's token group, handed out one token per
// output item
// ---------------------------------------------------------------------------
module jtok_serializer (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            load,
    input  jtok_pkg::grp_t  grp,
    output logic            free,
    output logic            out_valid,
    input  logic            out_stall,
    output logic [3:0]      token_kind,
    output logic [15:0]     token_start,
    output logic [15:0]     token_length,
    output logic            last_of_run
);
    import jtok_pkg::*;

    grp_t        grp_reg;
    logic        valid_reg, valid_next;
    logic [1:0]  idx_reg, idx_next;
    logic        last;
    logic        take;

    assign last        = (idx_reg == grp_reg.cnt - 2'd1);
    assign take        = valid_reg && !out_stall;
    assign free        = !valid_reg || (take && last);

    assign out_valid    = valid_reg;
    assign token_kind   = grp_reg.tok[idx_reg].kind;
    assign token_start  = grp_reg.tok[idx_reg].start;
    assign token_length = grp_reg.tok[idx_reg].length;
    assign last_of_run  = last;

    always_comb
    begin
        valid_next = valid_reg;
        idx_next   = idx_reg;
        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = 2'd0;
        end
        else if (take)
        begin
            if (last)
                valid_next = 1'b0;
            else
                idx_next = idx_reg + 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 2'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            grp_reg <= grp;
    end

endmodule

// ----- hdl/json_tokenizer_core.sv -----
// path: a byte's first token passes the input register, then the result register
// throughput: one byte per cycle while each byte gives at most one token and out_stall
// is low; a byte that gives more tokens holds the next byte in the input register until
// its tokens are all handed out, as the result register hands out one token per unstalled cycle
// reset: asynchronous, clears scanner state, offsets and the valid flags of both registers
// ---------------------------------------------------------------------------
// json_tokenizer_core
// byte-wide json lexer: input register, scanner, token group serializer
// ---------------------------------------------------------------------------
module json_tokenizer_core #(
    parameter int unsigned MAX_DOCUMENT_BYTES = 65536,
    parameter int unsigned NUMBER_LIMIT       = 128
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  data_byte,
    input  logic        end_of_input,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [3:0]  token_kind,
    output logic [15:0] token_start,
    output logic [15:0] token_length,
    output logic        last_of_run
);
    import jtok_pkg::*;

    logic        in_valid_reg, in_valid_next;
    logic [7:0]  byte_reg;
    logic        eoi_reg;
    logic        advance;
    logic        accept;
    logic        grp_free;
    grp_t        grp;

    // a byte with no tokens may pass while earlier tokens still wait
    assign advance  = in_valid_reg && (grp_free || grp.cnt == 2'd0);
    assign in_stall = in_valid_reg && !advance;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (accept)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else
            in_valid_reg <= in_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            byte_reg <= data_byte;
            eoi_reg  <= end_of_input;
        end
    end

    jtok_lexer #(
        .MAX_DOCUMENT_BYTES (MAX_DOCUMENT_BYTES),
        .NUMBER_LIMIT       (NUMBER_LIMIT)
    ) u_lexer (
        .clk          (clk),
        .rst_n        (rst_n),
        .step         (advance),
        .data_byte    (byte_reg),
        .end_of_input (eoi_reg),
        .grp          (grp)
    );

    jtok_serializer u_ser (
        .clk          (clk),
        .rst_n        (rst_n),
        .load         (advance && grp.cnt != 2'd0),
        .grp          (grp),
        .free         (grp_free),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .token_kind   (token_kind),
        .token_start  (token_start),
        .token_length (token_length),
        .last_of_run  (last_of_run)
    );

endmodule

// ----- hdl/jtok_checker.sv -----
// ---------------------------------------------------------------------------
// jtok_checker
// port-level checks on the tokenizer output, bound to the top level
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module jtok_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [3:0]  token_kind,
    input  logic [15:0] token_length,
    input  logic        last_of_run
);
    import jtok_pkg::*;

    `ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid)
    `ASSERT_SAME(a_kind_range, out_valid, token_kind <= KIND_END)
    `ASSERT_SAME(a_end_closes, out_valid && token_kind == KIND_END, token_length == 16'd0 && last_of_run)
    `ASSERT_SAME(a_punct_len, out_valid && token_kind <= KIND_COMMA, token_length == 16'd1)

endmodule

bind json_tokenizer_core jtok_checker u_jtok_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .token_kind   (token_kind),
    .token_length (token_length),
    .last_of_run  (last_of_run)
);

// ----- tb/json_tokenizer_core_test.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// json_tokenizer_core_test
// feeds json documents byte by byte into the tokenizer and checks every token
// against a byte-level lexer model, with random gaps on both handshakes
// ---------------------------------------------------------------------------
import jtok_pkg::*;

typedef enum logic [2:0] {
    LEX_IDLE,
    LEX_NUMBER,
    LEX_STRING,
    LEX_LITERAL,
    LEX_ERROR
} lex_mode_e;

typedef struct packed {
    logic [3:0]  kind;
    logic [15:0] start;
    logic [15:0] length;
    logic        last;
} token_rec_t;

typedef struct packed {
    logic [7:0] data;
    logic       eoi;
} byte_item_t;

class token_scoreboard;
    localparam int NUMBER_MAX_BYTES = 128;
    localparam logic [15:0] OFFSET_CAP = 16'hFFFF;

    token_rec_t expected_tokens[$];
    token_rec_t byte_tokens[$];
    int         mismatches;
    string      words[3];

    lex_mode_e   mode;
    logic [1:0]  num_phase;
    logic [1:0]  word_sel;
    logic [2:0]  word_idx;
    logic        after_backslash;
    logic [15:0] offset;
    logic [15:0] tok_start;
    logic [15:0] tok_len;

    function new();
        words[0] = "true";
        words[1] = "false";
        words[2] = "null";
        mismatches = 0;
        clear_state();
    endfunction

    function void clear_state();
        mode = LEX_IDLE;
        num_phase = 2'd0;
        word_sel = 2'd0;
        word_idx = 3'd0;
        after_backslash = 1'b0;
        offset = 16'd0;
        tok_start = 16'd0;
        tok_len = 16'd0;
    endfunction

    function logic [15:0] bump(logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function bit is_digit(logic [7:0] b);
        return b >= "0" && b <= "9";
    endfunction

    function bit is_sign(logic [7:0] b);
        return b == "+" || b == "-";
    endfunction

    function void add_token(logic [3:0] kind, logic [15:0] start, logic [15:0] length);
        token_rec_t t;
        if (byte_tokens.size() >= GROUP_SLOTS)
            return;
        t.kind = kind;
        t.start = start;
        t.length = length;
        t.last = 1'b0;
        byte_tokens.push_back(t);
    endfunction

    function void open_token(lex_mode_e m, logic [15:0] pos);
        mode = m;
        tok_start = pos;
        tok_len = 16'd1;
    endfunction

    // byte seen between tokens
    function void start_token(logic [7:0] b, logic [15:0] pos);
        if (b == " " || b == "\t" || b == "\n" || b == 8'h0D)
            return;
        case (b)
            "{": add_token(KIND_LBRACE, pos, 16'd1);
            "}": add_token(KIND_RBRACE, pos, 16'd1);
            "[": add_token(KIND_LBRACK, pos, 16'd1);
            "]": add_token(KIND_RBRACK, pos, 16'd1);
            ":": add_token(KIND_COLON, pos, 16'd1);
            ",": add_token(KIND_COMMA, pos, 16'd1);
            default:
            begin
                if (is_digit(b) || is_sign(b))
                begin
                    open_token(LEX_NUMBER, pos);
                    num_phase = is_digit(b) ? 2'd1 : 2'd0;
                end
                else if (b == "\"")
                begin
                    open_token(LEX_STRING, pos);
                    after_backslash = 1'b0;
                end
                else if (b == "t" || b == "f" || b == "n")
                begin
                    open_token(LEX_LITERAL, pos);
                    word_sel = (b == "t") ? 2'd0 : (b == "f") ? 2'd1 : 2'd2;
                    word_idx = 3'd1;
                end
                else
                begin
                    add_token(KIND_ERROR, pos, 16'd1);
                    mode = LEX_ERROR;
                end
            end
        endcase
    endfunction

    // phase 1 and 3 mean at least one digit was seen
    function bit close_number();
        if (num_phase == 2'd1 || num_phase == 2'd3)
        begin
            add_token(KIND_NUMBER, tok_start, tok_len);
            mode = LEX_IDLE;
            return 1'b1;
        end
        add_token(KIND_ERROR, tok_start, tok_len);
        mode = LEX_ERROR;
        return 1'b0;
    endfunction

    function void extend_number(logic [7:0] b);
        bit bad;
        bad = 1'b0;
        if (int'(tok_len) + 1 > NUMBER_MAX_BYTES || is_sign(b))
            bad = 1'b1;
        else if (is_digit(b))
            num_phase = (num_phase >= 2'd2) ? 2'd3 : 2'd1;
        else if (num_phase <= 2'd1)
            num_phase = (num_phase == 2'd0) ? 2'd2 : 2'd3;
        else
            bad = 1'b1;
        tok_len = bump(tok_len);
        if (bad)
        begin
            add_token(KIND_ERROR, tok_start, tok_len);
            mode = LEX_ERROR;
        end
    endfunction

    function void note_byte(logic [7:0] b, logic eoi);
        logic [15:0] pos;
        logic [7:0]  letter;
        bit          fresh;
        pos = offset;
        fresh = 1'b0;
        byte_tokens.delete();
        case (mode)
            LEX_NUMBER:
            begin
                if (is_digit(b) || is_sign(b) || b == ".")
                    extend_number(b);
                else
                    fresh = close_number();
            end
            LEX_STRING:
            begin
                tok_len = bump(tok_len);
                if (b == "\"" && !after_backslash)
                begin
                    add_token(KIND_STRING, tok_start, tok_len);
                    mode = LEX_IDLE;
                end
                after_backslash = (b == "\\");
            end
            LEX_LITERAL:
            begin
                letter = words[word_sel][word_idx];
                if (b == letter)
                begin
                    tok_len = bump(tok_len);
                    word_idx = word_idx + 3'd1;
                    if (int'(word_idx) >= words[word_sel].len())
                    begin
                        add_token(KIND_TRUE + {2'b00, word_sel}, tok_start, tok_len);
                        mode = LEX_IDLE;
                    end
                end
                else
                begin
                    add_token(KIND_ERROR, tok_start, bump(tok_len));
                    mode = LEX_ERROR;
                end
            end
            LEX_IDLE: fresh = 1'b1;
            default: mode = LEX_ERROR;
        endcase
        if (fresh)
            start_token(b, pos);
        if (offset < OFFSET_CAP)
            offset = offset + 16'd1;
        if (eoi)
        begin
            // whatever is open gets closed before the end token
            if (mode == LEX_NUMBER)
                void'(close_number());
            else if (mode == LEX_STRING)
                add_token(KIND_ERROR, tok_start, tok_len);
            else if (mode == LEX_LITERAL)
                add_token(KIND_TRUE + {2'b00, word_sel}, tok_start, tok_len);
            add_token(KIND_END, offset, 16'd0);
            clear_state();
        end
        if (byte_tokens.size() > 0)
            byte_tokens[byte_tokens.size() - 1].last = 1'b1;
        foreach (byte_tokens[i])
            expected_tokens.push_back(byte_tokens[i]);
    endfunction

    task report_mismatch(string msg);
        if (mismatches < 50)
            $display("token mismatch: %s", msg);
        mismatches++;
    endtask

    task check_token(logic [3:0] kind, logic [15:0] start, logic [15:0] length, logic last);
        token_rec_t want;
        if (expected_tokens.size() == 0)
        begin
            report_mismatch($sformatf("unexpected token kind %0d start %0d length %0d",
                                      kind, start, length));
            return;
        end
        want = expected_tokens.pop_front();
        if (kind !== want.kind)
            report_mismatch($sformatf("kind %0d, want %0d (start %0d)", kind, want.kind,
                                      want.start));
        if (start !== want.start)
            report_mismatch($sformatf("start %0d, want %0d", start, want.start));
        if (length !== want.length)
            report_mismatch($sformatf("length %0d, want %0d (start %0d)", length,
                                      want.length, want.start));
        if (last !== want.last)
            report_mismatch($sformatf("last_of_run %0b, want %0b (start %0d)", last,
                                      want.last, want.start));
    endtask
endclass

module json_tokenizer_core_test;

    localparam int unsigned CYCLE_LIMIT  = 600000;
    localparam int          DRAIN_CYCLES = 16;
    localparam int          PHASE_BYTES  = 30;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  data_byte = 8'h00;
    logic        end_of_input = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [3:0]  token_kind;
    logic [15:0] token_start;
    logic [15:0] token_length;
    logic        last_of_run;

    token_scoreboard board = new();
    byte_item_t      doc_bytes[$];
    int unsigned     cycle_count = 0;
    int              send_gap_pct = 0;
    int              recv_gap_pct = 0;

    json_tokenizer_core #(
        .MAX_DOCUMENT_BYTES(65536),
        .NUMBER_LIMIT(128)
    ) u_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .data_byte(data_byte),
        .end_of_input(end_of_input),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .token_kind(token_kind),
        .token_start(token_start),
        .token_length(token_length),
        .last_of_run(last_of_run)
    );

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // one window in four never idles
    function automatic bit take_gap(int pct);
        return cycle_count[5:4] != 2'b00 && $urandom_range(0, 99) < pct;
    endfunction

    // ---- document builders ----

    function automatic void put(logic [7:0] c);
        byte_item_t it;
        it.data = c;
        it.eoi = 1'b0;
        doc_bytes.push_back(it);
    endfunction

    function automatic void put_text(string s);
        for (int i = 0; i < s.len(); i++)
            put(s[i]);
    endfunction

    function automatic void end_doc();
        doc_bytes[doc_bytes.size() - 1].eoi = 1'b1;
    endfunction

    function automatic void put_blank();
        if ($urandom_range(0, 3) == 0)
        begin
            case ($urandom_range(0, 3))
                0: put(" ");
                1: put("\t");
                2: put("\n");
                default: put(8'h0D);
            endcase
        end
    endfunction

    function automatic void put_digits(int lo, int hi);
        int n;
        n = $urandom_range(lo, hi);
        for (int i = 0; i < n; i++)
            put(8'("0" + $urandom_range(0, 9)));
    endfunction

    function automatic void put_number();
        if ($urandom_range(0, 3) == 0)
            put("-");
        else if ($urandom_range(0, 7) == 0)
            put("+");
        put_digits(1, 4);
        if ($urandom_range(0, 2) == 0)
        begin
            put(".");
            put_digits(1, 3);
        end
    endfunction

    function automatic void put_quoted();
        int          n;
        logic [7:0]  c;
        n = $urandom_range(0, 5);
        put("\"");
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 4) == 0)
            begin
                put("\\");
                put($urandom_range(0, 1) ? 8'("\"") : 8'("n"));
            end
            else
            begin
                c = 8'($urandom_range(0, 255));
                if (c == "\"" || c == "\\")
                    c = "a";
                put(c);
            end
        end
        put("\"");
    endfunction

    function automatic void put_word();
        case ($urandom_range(0, 2))
            0: put_text("true");
            1: put_text("false");
            default: put_text("null");
        endcase
    endfunction

    function automatic void put_value(int depth);
        int n;
        n = $urandom_range(0, 3);
        case ($urandom_range(0, depth >= 2 ? 2 : 4))
            0: put_number();
            1: put_quoted();
            2: put_word();
            3:
            begin
                put("[");
                for (int i = 0; i < n; i++)
                begin
                    if (i > 0)
                        put(",");
                    put_blank();
                    put_value(depth + 1);
                    put_blank();
                end
                put("]");
            end
            default:
            begin
                put("{");
                for (int i = 0; i < n; i++)
                begin
                    if (i > 0)
                        put(",");
                    put_blank();
                    put_quoted();
                    put_blank();
                    put(":");
                    put_blank();
                    put_value(depth + 1);
                end
                put("}");
            end
        endcase
    endfunction

    function automatic void put_document();
        put_blank();
        put_value(0);
        put_blank();
        end_doc();
    endfunction

    // numbers that break the sign, point or digit rules
    function automatic void put_odd_number();
        case ($urandom_range(0, 3))
            0: put(".");
            1:
            begin
                put_digits(1, 2);
                put(".");
                put_digits(0, 2);
                put(".");
            end
            2:
            begin
                put_digits(1, 3);
                put($urandom_range(0, 1) ? 8'("+") : 8'("-"));
            end
            default:
            begin
                put($urandom_range(0, 1) ? 8'("+") : 8'("-"));
                if ($urandom_range(0, 1))
                    put(".");
                if ($urandom_range(0, 1))
                    put("]");
            end
        endcase
        if ($urandom_range(0, 1))
            put(",");
        end_doc();
    endfunction

    function automatic void add_random_docs(int budget);
        int first;
        int doc_first;
        int keep;
        first = doc_bytes.size();
        while (doc_bytes.size() - first < budget)
        begin
            doc_first = doc_bytes.size();
            case ($urandom_range(0, 9))
                6:
                begin
                    // well-formed document cut short
                    put_value(0);
                    keep = $urandom_range(1, doc_bytes.size() - doc_first);
                    while (doc_bytes.size() > doc_first + keep)
                        void'(doc_bytes.pop_back());
                    end_doc();
                end
                7:
                begin
                    put_document();
                    keep = $urandom_range(doc_first, doc_bytes.size() - 1);
                    doc_bytes[keep].data = 8'($urandom_range(0, 255));
                end
                8:
                begin
                    keep = $urandom_range(1, 6);
                    for (int i = 0; i < keep; i++)
                        put(8'($urandom_range(0, 255)));
                    end_doc();
                end
                9: put_odd_number();
                default: put_document();
            endcase
        end
    endfunction

    // ---- handshakes ----

    task automatic send_items();
        bit         fired;
        byte_item_t it;
        forever
        begin
            @(negedge clk);
            fired = in_valid && !in_stall;
            @(posedge clk);
            if (fired)
                board.note_byte(data_byte, end_of_input);
            if (!in_valid || fired)
            begin
                if (doc_bytes.size() == 0)
                begin
                    in_valid <= 1'b0;
                    return;
                end
                if (take_gap(send_gap_pct))
                    in_valid <= 1'b0;
                else
                begin
                    it = doc_bytes.pop_front();
                    in_valid <= 1'b1;
                    data_byte <= it.data;
                    end_of_input <= it.eoi;
                end
            end
        end
    endtask

    initial
    begin : token_sink
        bit          got;
        logic [3:0]  kind;
        logic [15:0] start;
        logic [15:0] length;
        logic        last;
        forever
        begin
            @(negedge clk);
            got = out_valid && !out_stall;
            kind = token_kind;
            start = token_start;
            length = token_length;
            last = last_of_run;
            @(posedge clk);
            if (got)
                board.check_token(kind, start, length, last);
            out_stall <= take_gap(recv_gap_pct);
        end
    end

    initial
    begin
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        send_gap_pct = 28;
        recv_gap_pct = 58;
        // escaped quote inside a string, signed number with a point
        put_text("{\"\\\"\":-1.5}");
        end_doc();
        // literal cut short by end of input
        put_text("[tr");
        end_doc();
        put_text("nx");
        end_doc();
        // sign with no digit, then the comma is ignored
        put_text("-,");
        end_doc();
        put(8'hFF);
        put(8'h00);
        end_doc();
        // whitespace, then an open string at end of input
        put_text(" \t");
        put(8'h0D);
        put_text("\n\"q");
        end_doc();
        add_random_docs(PHASE_BYTES);
        send_items();

        send_gap_pct = 58;
        recv_gap_pct = 28;
        add_random_docs(PHASE_BYTES);
        send_items();

        send_gap_pct = 0;
        recv_gap_pct = 0;
        add_random_docs(PHASE_BYTES);
        put_document();
        send_items();

        while (board.expected_tokens.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (board.mismatches == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
